>>> hw/rtl/lta_pkg.sv
// shared constants, types and helpers of the text line assembler
package lta_pkg;

    localparam int BYTE_W      = 8;
    localparam int STORE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int LEN_W       = $clog2(STORE_DEPTH + 1);
    localparam int MAX_LINE_DEF = 64;

    localparam logic [BYTE_W-1:0] CH_TAB  = 8'h09;
    localparam logic [BYTE_W-1:0] CH_FF   = 8'h0C;
    localparam logic [BYTE_W-1:0] CH_LF   = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR   = 8'h0D;
    localparam logic [BYTE_W-1:0] KEEP_LO = 8'h20;
    localparam logic [BYTE_W-1:0] KEEP_HI = 8'h7F;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [BYTE_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_store_req;

    function automatic logic is_kept(input logic [BYTE_W-1:0] b);
        logic k;
        k = (b == CH_TAB) || (b == CH_FF) || ((b >= KEEP_LO) && (b <= KEEP_HI));
        return k;
    endfunction

endpackage

>>> hw/rtl/lta_if.sv
// request channel interfaces for received bytes and line characters
interface lta_in_if import lta_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface lta_out_if import lta_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_char;
    logic              char_valid;
    logic              line_end;

    modport source (output valid, output out_char, output char_valid, output line_end,
                    input ready);
    modport sink   (input valid, input out_char, input char_valid, input line_end,
                    output ready);
endinterface

>>> hw/rtl/lta_store.sv
// line store: ring of characters, one write and one registered read port
module lta_store import lta_pkg::*; (
    input  logic              i_clk,
    input  t_store_req        i_req,
    output logic [BYTE_W-1:0] o_rd_data
);

    logic [BYTE_W-1:0] r_mem [STORE_DEPTH];
    logic [BYTE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rd_data <= r_mem[i_req.raddr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hw/rtl/lta_ctrl.sv
// byte classification, line pointers, emit sequencer and output register
module lta_ctrl import lta_pkg::*; #(
    parameter int MAX_LINE = MAX_LINE_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    lta_in_if.sink            i_in,
    lta_out_if.source         o_out,
    output t_store_req        o_req,
    input  logic [BYTE_W-1:0] i_rd_data
);

    localparam int HALF = MAX_LINE / 2;
    localparam logic [LEN_W-1:0]  MAX_LEN  = LEN_W'(MAX_LINE);
    localparam logic [LEN_W-1:0]  KEEP_LEN = LEN_W'(MAX_LINE - HALF);
    localparam logic [ADDR_W-1:0] HALF_A   = ADDR_W'(HALF);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_EMPTY = 3'b010,
        S_EMIT  = 3'b100
    } t_state;

    t_state            r_state, n_state;
    logic              r_pend, n_pend;
    logic              r_store_after, n_store_after;
    logic [ADDR_W-1:0] r_start, n_start;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [ADDR_W-1:0] r_idx, n_idx;
    logic [BYTE_W-1:0] r_byte, n_byte;
    logic              r_ovalid, n_ovalid;
    logic [BYTE_W-1:0] r_ochar, n_ochar;
    logic              r_ocv, n_ocv;
    logic              r_olast, n_olast;

    t_store_req        req;
    logic              out_free;
    logic              is_last;
    logic              full;
    logic [ADDR_W-1:0] adj_start;
    logic [LEN_W-1:0]  adj_len;

    assign out_free = !r_ovalid || o_out.ready;
    assign is_last  = ({1'b0, r_idx} == (r_len - LEN_W'(1)));
    assign full     = (r_len >= MAX_LEN);
    // overlong line drops its oldest half before the new byte goes in
    assign adj_start = full ? ADDR_W'(r_start + HALF_A) : r_start;
    assign adj_len   = full ? KEEP_LEN : r_len;

    always_comb begin
        n_state       = r_state;
        n_pend        = r_pend;
        n_store_after = r_store_after;
        n_start       = r_start;
        n_len         = r_len;
        n_idx         = r_idx;
        n_byte        = r_byte;
        n_ovalid      = r_ovalid;
        n_ochar       = r_ochar;
        n_ocv         = r_ocv;
        n_olast       = r_olast;
        req           = '0;
        req.raddr     = r_start;
        req.waddr     = ADDR_W'(adj_start + adj_len[ADDR_W-1:0]);
        req.wdata     = i_in.in_byte;

        if (r_ovalid && o_out.ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    logic go_emit;
                    go_emit = 1'b0;
                    if (i_in.in_byte == CH_CR) begin
                        if (r_pend) begin
                            go_emit = 1'b1;
                        end else begin
                            n_pend = 1'b1;
                        end
                    end else if (i_in.in_byte == CH_LF) begin
                        n_pend  = 1'b0;
                        go_emit = 1'b1;
                    end else if (is_kept(i_in.in_byte)) begin
                        if (r_pend) begin
                            n_pend        = 1'b0;
                            n_store_after = 1'b1;
                            n_byte        = i_in.in_byte;
                            go_emit       = 1'b1;
                        end else begin
                            req.we  = 1'b1;
                            n_start = adj_start;
                            n_len   = adj_len + LEN_W'(1);
                        end
                    end
                    if (go_emit) begin
                        n_idx = '0;
                        if (r_len == '0) begin
                            n_state = S_EMPTY;
                        end else begin
                            req.re  = 1'b1;
                            n_state = S_EMIT;
                        end
                    end
                end
            end
            S_EMPTY: begin
                if (out_free) begin
                    n_ovalid      = 1'b1;
                    n_ochar       = '0;
                    n_ocv         = 1'b0;
                    n_olast       = 1'b1;
                    n_state       = S_IDLE;
                    n_start       = '0;
                    n_store_after = 1'b0;
                    if (r_store_after) begin
                        req.we    = 1'b1;
                        req.waddr = '0;
                        req.wdata = r_byte;
                        n_len     = LEN_W'(1);
                    end else begin
                        n_len = '0;
                    end
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_ochar  = i_rd_data;
                    n_ocv    = 1'b1;
                    n_olast  = is_last;
                    if (is_last) begin
                        n_state       = S_IDLE;
                        n_start       = '0;
                        n_store_after = 1'b0;
                        if (r_store_after) begin
                            req.we    = 1'b1;
                            req.waddr = '0;
                            req.wdata = r_byte;
                            n_len     = LEN_W'(1);
                        end else begin
                            n_len = '0;
                        end
                    end else begin
                        // prefetch next character while this one goes out
                        req.re    = 1'b1;
                        req.raddr = ADDR_W'(r_start + r_idx + ADDR_W'(1));
                        n_idx     = ADDR_W'(r_idx + ADDR_W'(1));
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_pend        <= 1'b0;
            r_store_after <= 1'b0;
            r_start       <= '0;
            r_len         <= '0;
            r_idx         <= '0;
            r_ovalid      <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_pend        <= n_pend;
            r_store_after <= n_store_after;
            r_start       <= n_start;
            r_len         <= n_len;
            r_idx         <= n_idx;
            r_ovalid      <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte  <= n_byte;
        r_ochar <= n_ochar;
        r_ocv   <= n_ocv;
        r_olast <= n_olast;
    end

    assign i_in.ready       = (r_state == S_IDLE);
    assign o_out.valid      = r_ovalid;
    assign o_out.out_char   = r_ochar;
    assign o_out.char_valid = r_ocv;
    assign o_out.line_end   = r_olast;
    assign o_req            = req;

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= MAX_LEN)
        else $error("line length beyond maximum");

    a_idx_in_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> ({1'b0, r_idx} < r_len))
        else $error("emit index outside line");

    a_emit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && out_free && is_last)
            |=> (r_state == S_IDLE && r_len <= LEN_W'(1) && r_start == '0))
        else $error("line not cleared after last character");

    a_write_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req.we && r_state == S_EMIT) |-> (out_free && is_last && r_store_after))
        else $error("store written in the middle of an emitted line");

endmodule

>>> hw/rtl/text_line_assembler.sv
// top level of the cr/lf text line assembler
//
//  channel  | dir | handshake     | payload
//  i_in     | in  | valid / ready | in_byte
//  o_out    | out | valid / ready | out_char, char_valid, line_end
//
// a byte that completes no line is taken while idle; the byte that completes a
// line holds the input while the line is read out of the line store, whose
// read port is registered, one character per cycle while the output is free
// an empty line holds the input as well; a stalled output holds the sequencer
// i_rst_n is synchronous, active low; the line store itself is not cleared
// a finished character waits in the output register while the next byte is taken
module text_line_assembler import lta_pkg::*; #(
    parameter int MAX_LINE = MAX_LINE_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lta_in_if.sink    i_in,
    lta_out_if.source o_out
);

    t_store_req        req;
    logic [BYTE_W-1:0] rd_data;

    lta_ctrl #(
        .MAX_LINE (MAX_LINE)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_out     (o_out),
        .o_req     (req),
        .i_rd_data (rd_data)
    );

    lta_store u_store (
        .i_clk     (i_clk),
        .i_req     (req),
        .o_rd_data (rd_data)
    );

endmodule
